>>> sv/fmvrs_pkg.sv
// Shared types, constants and lookup tables for the FM voice register sequencer.
package fmvrs_pkg;

    // Number of voice channels that produce register writes.
    localparam int CHANNEL_COUNT = 9;

    // Command opcodes.
    localparam logic [1:0] OP_KEY_OFF      = 2'd0;
    localparam logic [1:0] OP_PATCH        = 2'd1;
    localparam logic [1:0] OP_KEY_ON       = 2'd2;
    localparam logic [1:0] OP_PATCH_KEY_ON = 2'd3;

    // Pan selection codes on the input and the pan nibble they map to.
    localparam logic [1:0] PSEL_LEFT  = 2'd1;
    localparam logic [1:0] PSEL_RIGHT = 2'd2;
    localparam logic [1:0] PAN_LEFT   = 2'b01;
    localparam logic [1:0] PAN_RIGHT  = 2'b10;
    localparam logic [1:0] PAN_BOTH   = 2'b11;

    // Configuration register indexes.
    localparam logic CFG_MASTER_LEFT  = 1'b0;
    localparam logic CFG_MASTER_RIGHT = 1'b1;

    localparam logic [6:0] LEVEL_MAX  = 7'd100;
    localparam logic [4:0] VOLUME_MAX = 5'd25;

    // Synth register groups.
    localparam logic [7:0] REG_MULT  = 8'h20;
    localparam logic [7:0] REG_LEVEL = 8'h40;
    localparam logic [7:0] REG_ENV   = 8'h60;
    localparam logic [7:0] REG_SR    = 8'h80;
    localparam logic [7:0] REG_FNUM  = 8'hA0;
    localparam logic [7:0] REG_KEY   = 8'hB0;
    localparam logic [7:0] REG_PAN   = 8'hC0;
    localparam logic [7:0] REG_WAVE  = 8'hE0;
    localparam logic [7:0] MULT_VALUE = 8'h21;
    localparam logic [4:0] CAR_OFFSET = 5'd3;

    // Frequency arithmetic. The frequency number for block b is
    // floor((f * 2^(17-b) + CLOCK_DIV) / (2 * CLOCK_DIV)).
    localparam logic [16:0] FREQ_MIN  = 17'd16;
    localparam logic [16:0] FREQ_MAX  = 17'd99328;
    localparam int          CLOCK_DIV = 49716;
    localparam int          FNUM_MAX  = 1023;
    // A block fits when f * 2^(17-b) is below this bound.
    localparam logic [33:0] FNUM_LIMIT = 34'((FNUM_MAX + 1) * 2 * CLOCK_DIV - CLOCK_DIV);
    localparam int          FN_SHIFT   = 44;
    localparam logic [27:0] FN_RECIP   =
        28'(((64'd1 << FN_SHIFT) + 64'(2 * CLOCK_DIV) - 64'd1) / 64'(2 * CLOCK_DIV));

    // Carrier attenuation arithmetic: floor((v * m * 63 + 1250) / 2500).
    localparam int          ATT_DIV   = 2500;
    localparam int          ATT_ROUND = 1250;
    localparam int          ATT_SHIFT = 30;
    localparam logic [18:0] ATT_RECIP = 19'(((64'd1 << ATT_SHIFT) + 64'(ATT_DIV) - 64'd1)
                                            / 64'(ATT_DIV));

    // Port payloads.
    typedef struct packed {
        logic [1:0]  opcode;
        logic [3:0]  channel;
        logic [2:0]  wave_kind;
        logic [4:0]  voice_volume;
        logic [1:0]  pan_select;
        logic [16:0] frequency;
    } t_req;

    typedef struct packed {
        logic [7:0] reg_address;
        logic [7:0] reg_value;
        logic       last_write;
    } t_wr;

    // Fields common to every pipeline stage.
    typedef struct packed {
        logic [1:0] opcode;
        logic [3:0] channel;
        logic [2:0] wave_kind;
        logic [1:0] pan;
    } t_cmd_hdr;

    typedef struct packed {
        t_cmd_hdr    hdr;
        logic [4:0]  volume;
        logic [6:0]  level;
        logic [16:0] freq;
    } t_s1;

    typedef struct packed {
        t_cmd_hdr    hdr;
        logic [2:0]  blk;
        logic [26:0] fnum_num;
        logic [17:0] att_num;
    } t_s2;

    typedef struct packed {
        t_cmd_hdr    hdr;
        logic [2:0]  blk;
        logic [54:0] fnum_prod;
        logic [36:0] att_prod;
    } t_s3;

    typedef struct packed {
        t_cmd_hdr   hdr;
        logic [2:0] blk;
        logic [9:0] fnum;
        logic [5:0] atten;
    } t_cmd;

    // Write sequence steps.
    typedef enum logic [3:0] {
        ST_MULT_MOD  = 4'd0,
        ST_MULT_CAR  = 4'd1,
        ST_LEVEL_MOD = 4'd2,
        ST_LEVEL_CAR = 4'd3,
        ST_ENV_MOD   = 4'd4,
        ST_ENV_CAR   = 4'd5,
        ST_SR_MOD    = 4'd6,
        ST_SR_CAR    = 4'd7,
        ST_WAVE_MOD  = 4'd8,
        ST_WAVE_CAR  = 4'd9,
        ST_PAN       = 4'd10,
        ST_FNUM_LO   = 4'd11,
        ST_KEY_ON    = 4'd12,
        ST_KEY_OFF   = 4'd13
    } t_step;

    typedef struct packed {
        logic [2:0] waveform;
        logic [7:0] mod_tl;
        logic [3:0] feedback;
        logic [7:0] mod_env;
        logic [7:0] car_env;
        logic [7:0] mod_sr;
        logic [7:0] car_sr;
    } t_wave;

    // Modulator operator offset of each channel.
    function automatic logic [4:0] op_base(input logic [3:0] ch);
        logic [4:0] base;
        case (ch)
            4'd0:    base = 5'd0;
            4'd1:    base = 5'd1;
            4'd2:    base = 5'd2;
            4'd3:    base = 5'd8;
            4'd4:    base = 5'd9;
            4'd5:    base = 5'd10;
            4'd6:    base = 5'd16;
            4'd7:    base = 5'd17;
            4'd8:    base = 5'd18;
            default: base = 5'd0;
        endcase
        return base;
    endfunction

    // Operator settings per wave kind; unknown kinds play as sine.
    function automatic t_wave wave_entry(input logic [2:0] kind);
        t_wave w;
        case (kind)
            3'd1:    w = '{3'd1, 8'h12, 4'hE, 8'hF0, 8'hF3, 8'h05, 8'h05};
            3'd2:    w = '{3'd6, 8'h30, 4'h4, 8'hF0, 8'hE4, 8'h05, 8'h05};
            3'd3:    w = '{3'd4, 8'h08, 4'hA, 8'hF0, 8'hF2, 8'h05, 8'h05};
            3'd4:    w = '{3'd7, 8'h00, 4'hE, 8'hFF, 8'hFF, 8'h11, 8'h11};
            default: w = '{3'd0, 8'h16, 4'h8, 8'hF0, 8'hF0, 8'h05, 8'h05};
        endcase
        return w;
    endfunction

endpackage

>>> sv/fmvrs_front.sv
// Front pipeline stages: input clamping, level selection, block search and numerators.
module fmvrs_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  fmvrs_pkg::t_req  i_req,
    input  logic [6:0]       i_master_left,
    input  logic [6:0]       i_master_right,
    output logic             o_valid,
    input  logic             i_ready,
    output fmvrs_pkg::t_s2   o_s2
);

    logic             r_v1;
    logic             r_v2;
    fmvrs_pkg::t_s1   r_s1;
    fmvrs_pkg::t_s2   r_s2;
    fmvrs_pkg::t_s1   n_s1;
    fmvrs_pkg::t_s2   n_s2;
    logic             en1;
    logic             en2;
    logic             ch_ok;

    assign en2     = !r_v2 || i_ready;
    assign en1     = !r_v1 || en2;
    assign o_ready = en1;
    assign o_valid = r_v2;
    assign o_s2    = r_s2;
    assign ch_ok   = i_req.channel < 4'(fmvrs_pkg::CHANNEL_COUNT);

    // Stage 1: saturate volume, map pan, pick the master level, clamp frequency.
    always_comb begin
        logic [7:0] level_sum;
        level_sum = {1'b0, i_master_left} + {1'b0, i_master_right};
        n_s1.hdr.opcode    = i_req.opcode;
        n_s1.hdr.channel   = i_req.channel;
        n_s1.hdr.wave_kind = i_req.wave_kind;
        n_s1.volume = (i_req.voice_volume > fmvrs_pkg::VOLUME_MAX) ?
                      fmvrs_pkg::VOLUME_MAX : i_req.voice_volume;
        if (i_req.pan_select == fmvrs_pkg::PSEL_LEFT) begin
            n_s1.hdr.pan = fmvrs_pkg::PAN_LEFT;
            n_s1.level   = i_master_left;
        end else if (i_req.pan_select == fmvrs_pkg::PSEL_RIGHT) begin
            n_s1.hdr.pan = fmvrs_pkg::PAN_RIGHT;
            n_s1.level   = i_master_right;
        end else begin
            n_s1.hdr.pan = fmvrs_pkg::PAN_BOTH;
            n_s1.level   = level_sum[7:1];
        end
        if (i_req.frequency < fmvrs_pkg::FREQ_MIN) begin
            n_s1.freq = fmvrs_pkg::FREQ_MIN;
        end else if (i_req.frequency > fmvrs_pkg::FREQ_MAX) begin
            n_s1.freq = fmvrs_pkg::FREQ_MAX;
        end else begin
            n_s1.freq = i_req.frequency;
        end
    end

    // Stage 2: find the lowest block whose frequency number fits in ten bits,
    // and form both dividends.
    always_comb begin
        logic [6:0]  fits;
        logic [2:0]  blk;
        logic [33:0] shifted;
        logic [11:0] vm;
        logic [17:0] vm63;
        for (int b = 0; b < 7; b++) begin
            fits[b] = (({17'd0, r_s1.freq} << (17 - b)) < fmvrs_pkg::FNUM_LIMIT);
        end
        blk = 3'd7;
        for (int b = 6; b >= 0; b--) begin
            if (fits[b]) begin
                blk = 3'(b);
            end
        end
        shifted = {17'd0, r_s1.freq} << (5'd17 - {2'd0, blk});
        vm   = {7'd0, r_s1.volume} * {5'd0, r_s1.level};
        vm63 = {vm, 6'd0} - {6'd0, vm};
        n_s2.hdr      = r_s1.hdr;
        n_s2.blk      = blk;
        n_s2.fnum_num = shifted[26:0] + 27'(fmvrs_pkg::CLOCK_DIV);
        n_s2.att_num  = vm63 + 18'(fmvrs_pkg::ATT_ROUND);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_valid && ch_ok;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1 <= n_s1;
        end
        if (en2) begin
            r_s2 <= n_s2;
        end
    end

endmodule

>>> sv/fmvrs_math.sv
// Back pipeline stages: reciprocal multiplies and final frequency number and attenuation.
module fmvrs_math (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  fmvrs_pkg::t_s2   i_s2,
    output logic             o_valid,
    input  logic             i_ready,
    output fmvrs_pkg::t_cmd  o_cmd
);

    logic             r_v3;
    logic             r_v4;
    fmvrs_pkg::t_s3   r_s3;
    fmvrs_pkg::t_cmd  r_cmd;
    fmvrs_pkg::t_cmd  n_cmd;
    logic             en3;
    logic             en4;

    assign en4     = !r_v4 || i_ready;
    assign en3     = !r_v3 || en4;
    assign o_ready = en3;
    assign o_valid = r_v4;
    assign o_cmd   = r_cmd;

    // Stage 4: take the quotients from the products and saturate them.
    always_comb begin
        logic [10:0] fn_raw;
        logic [6:0]  q;
        fn_raw = r_s3.fnum_prod[54:fmvrs_pkg::FN_SHIFT];
        q      = r_s3.att_prod[36:fmvrs_pkg::ATT_SHIFT];
        n_cmd.hdr = r_s3.hdr;
        n_cmd.blk = r_s3.blk;
        if (fn_raw == 11'd0) begin
            n_cmd.fnum = 10'd1;
        end else if (fn_raw > 11'(fmvrs_pkg::FNUM_MAX)) begin
            n_cmd.fnum = 10'(fmvrs_pkg::FNUM_MAX);
        end else begin
            n_cmd.fnum = fn_raw[9:0];
        end
        n_cmd.atten = (q > 7'd63) ? 6'd0 : 6'(7'd63 - q);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en3) begin
                r_v3 <= i_valid;
            end
            if (en4) begin
                r_v4 <= r_v3;
            end
        end
    end

    // Stage 3: both divisions by a constant become multiplies by a reciprocal.
    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_s3.hdr       <= i_s2.hdr;
            r_s3.blk       <= i_s2.blk;
            r_s3.fnum_prod <= {28'd0, i_s2.fnum_num} * {27'd0, fmvrs_pkg::FN_RECIP};
            r_s3.att_prod  <= {19'd0, i_s2.att_num} * {18'd0, fmvrs_pkg::ATT_RECIP};
        end
        if (en4) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

>>> sv/fmvrs_seq.sv
// Write sequencer: turns one finished command into its register writes.
module fmvrs_seq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  fmvrs_pkg::t_cmd  i_cmd,
    output logic             o_valid,
    input  logic             i_ready,
    output fmvrs_pkg::t_wr   o_wr
);

    fmvrs_pkg::t_step r_step;
    fmvrs_pkg::t_step n_step;
    logic             r_busy;
    logic             n_busy;
    fmvrs_pkg::t_cmd  r_cmd;
    logic             r_out_valid;
    fmvrs_pkg::t_wr   r_out;
    fmvrs_pkg::t_wr   wr;
    fmvrs_pkg::t_wave wave;
    fmvrs_pkg::t_step start;
    logic [7:0]       mod;
    logic [7:0]       car;
    logic [7:0]       ch;
    logic             last;
    logic             take;
    logic             accept;
    logic             is_patch;

    assign o_valid = r_out_valid;
    assign o_wr    = r_out;
    assign wave    = fmvrs_pkg::wave_entry(r_cmd.hdr.wave_kind);
    assign mod     = {3'd0, fmvrs_pkg::op_base(r_cmd.hdr.channel)};
    assign car     = {3'd0, fmvrs_pkg::op_base(r_cmd.hdr.channel) + fmvrs_pkg::CAR_OFFSET};
    assign ch      = {4'd0, r_cmd.hdr.channel};

    always_comb begin
        is_patch = (r_cmd.hdr.opcode == fmvrs_pkg::OP_PATCH);
        last     = 1'b0;
        case (r_step)
            fmvrs_pkg::ST_MULT_MOD:  wr = '{fmvrs_pkg::REG_MULT + mod, fmvrs_pkg::MULT_VALUE, 1'b0};
            fmvrs_pkg::ST_MULT_CAR:  wr = '{fmvrs_pkg::REG_MULT + car, fmvrs_pkg::MULT_VALUE, 1'b0};
            fmvrs_pkg::ST_LEVEL_MOD: wr = '{fmvrs_pkg::REG_LEVEL + mod, wave.mod_tl, 1'b0};
            fmvrs_pkg::ST_LEVEL_CAR: wr = '{fmvrs_pkg::REG_LEVEL + car, {2'd0, r_cmd.atten}, 1'b0};
            fmvrs_pkg::ST_ENV_MOD:   wr = '{fmvrs_pkg::REG_ENV + mod, wave.mod_env, 1'b0};
            fmvrs_pkg::ST_ENV_CAR:   wr = '{fmvrs_pkg::REG_ENV + car, wave.car_env, 1'b0};
            fmvrs_pkg::ST_SR_MOD:    wr = '{fmvrs_pkg::REG_SR + mod, wave.mod_sr, 1'b0};
            fmvrs_pkg::ST_SR_CAR:    wr = '{fmvrs_pkg::REG_SR + car, wave.car_sr, 1'b0};
            fmvrs_pkg::ST_WAVE_MOD:  wr = '{fmvrs_pkg::REG_WAVE + mod, {5'd0, wave.waveform}, 1'b0};
            fmvrs_pkg::ST_WAVE_CAR:  wr = '{fmvrs_pkg::REG_WAVE + car, {5'd0, wave.waveform}, 1'b0};
            fmvrs_pkg::ST_PAN: begin
                last = is_patch;
                wr   = '{fmvrs_pkg::REG_PAN + ch, {2'd0, r_cmd.hdr.pan, wave.feedback}, is_patch};
            end
            fmvrs_pkg::ST_FNUM_LO:   wr = '{fmvrs_pkg::REG_FNUM + ch, r_cmd.fnum[7:0], 1'b0};
            fmvrs_pkg::ST_KEY_ON: begin
                last = 1'b1;
                wr   = '{fmvrs_pkg::REG_KEY + ch, {3'b001, r_cmd.blk, r_cmd.fnum[9:8]}, 1'b1};
            end
            fmvrs_pkg::ST_KEY_OFF: begin
                last = 1'b1;
                wr   = '{fmvrs_pkg::REG_KEY + ch, 8'd0, 1'b1};
            end
            default: begin
                last = 1'b1;
                wr   = '{8'd0, 8'd0, 1'b1};
            end
        endcase
    end

    // A new command is taken in the cycle its predecessor's last write goes out.
    assign take    = r_busy && (!r_out_valid || i_ready);
    assign o_ready = !r_busy || (take && last);
    assign accept  = i_valid && o_ready;

    always_comb begin
        case (i_cmd.hdr.opcode)
            fmvrs_pkg::OP_KEY_OFF: start = fmvrs_pkg::ST_KEY_OFF;
            fmvrs_pkg::OP_KEY_ON:  start = fmvrs_pkg::ST_FNUM_LO;
            default:               start = fmvrs_pkg::ST_MULT_MOD;
        endcase
        n_step = r_step;
        n_busy = r_busy;
        if (accept) begin
            n_step = start;
            n_busy = 1'b1;
        end else if (take) begin
            if (last) begin
                n_busy = 1'b0;
            end else begin
                n_step = fmvrs_pkg::t_step'(4'(r_step) + 4'd1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= fmvrs_pkg::ST_MULT_MOD;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_step <= n_step;
            r_busy <= n_busy;
            if (take) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= i_cmd;
        end
        if (take) begin
            r_out <= wr;
        end
    end

endmodule

>>> sv/fm_voice_register_sequencer_top.sv
// Top level of the FM voice register sequencer: config registers and pipeline wiring.
//
//   Channel    Direction  Handshake           Payload
//   request    in         i_valid / o_ready   i_req  (fmvrs_pkg::t_req)
//   write      out        o_valid / i_ready   o_wr   (fmvrs_pkg::t_wr)
//   config     in         i_cfg_we            i_cfg_index, i_cfg_data
//
// A request passes four register stages (clamp and level select, block search and
// dividends, reciprocal multiplies, saturation) and then the write sequencer, whose
// output register holds each write. Without backpressure the sequencer emits one
// write per cycle: 1 for key off, 2 for key on, 11 for a patch and 13 for a patch
// with key on; the next command is taken only with the current one's last write.
// A request for a channel at or above the channel count is accepted and dropped in
// the first stage and produces no writes.
// Reset is synchronous and active low; it clears valid bits, the sequencer state and
// sets both master levels to 100. Backpressure on the write channel stalls every
// stage in place; nothing is lost or repeated.
module fm_voice_register_sequencer_top (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  fmvrs_pkg::t_req  i_req,
    output logic             o_valid,
    input  logic             i_ready,
    output fmvrs_pkg::t_wr   o_wr,
    input  logic             i_cfg_we,
    input  logic             i_cfg_index,
    input  logic [6:0]       i_cfg_data
);

    logic [6:0]       r_left_level;
    logic [6:0]       r_right_level;
    logic [6:0]       cfg_level;
    logic             front_valid;
    logic             math_ready;
    fmvrs_pkg::t_s2   front_s2;
    logic             math_valid;
    logic             seq_ready;
    fmvrs_pkg::t_cmd  math_cmd;

    // Master levels above 100 percent are saturated when written.
    assign cfg_level = (i_cfg_data > fmvrs_pkg::LEVEL_MAX) ? fmvrs_pkg::LEVEL_MAX : i_cfg_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_level  <= fmvrs_pkg::LEVEL_MAX;
            r_right_level <= fmvrs_pkg::LEVEL_MAX;
        end else begin
            if (i_cfg_we && i_cfg_index == fmvrs_pkg::CFG_MASTER_LEFT) begin
                r_left_level  <= cfg_level;
            end
            if (i_cfg_we && i_cfg_index == fmvrs_pkg::CFG_MASTER_RIGHT) begin
                r_right_level <= cfg_level;
            end
        end
    end

    fmvrs_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_req          (i_req),
        .i_master_left  (r_left_level),
        .i_master_right (r_right_level),
        .o_valid        (front_valid),
        .i_ready        (math_ready),
        .o_s2           (front_s2)
    );

    fmvrs_math u_math (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .o_ready (math_ready),
        .i_s2    (front_s2),
        .o_valid (math_valid),
        .i_ready (seq_ready),
        .o_cmd   (math_cmd)
    );

    fmvrs_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (math_valid),
        .o_ready (seq_ready),
        .i_cmd   (math_cmd),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_wr    (o_wr)
    );

endmodule
